[rtl/core/psg_pkg.sv]
package psg_pkg;

    // Build-time defaults
    localparam int DEF_MAX_CHIPS = 2;

    // Request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Block configuration register indexes
    localparam logic [1:0] CFG_CHIP_COUNT = 2'd0;
    localparam logic [1:0] CFG_STEP_INC   = 2'd1;
    localparam logic [1:0] CFG_GAIN       = 2'd2;

    localparam logic [1:0] RST_CHIP_COUNT = 2'd1;
    localparam logic [3:0] RST_STEP_INC   = 4'd9;
    localparam logic [3:0] RST_GAIN       = 4'd11;

    // Per-chip sound register map
    localparam logic [3:0] REG_TONE_A_LO = 4'd0;
    localparam logic [3:0] REG_TONE_A_HI = 4'd1;
    localparam logic [3:0] REG_TONE_B_LO = 4'd2;
    localparam logic [3:0] REG_TONE_B_HI = 4'd3;
    localparam logic [3:0] REG_TONE_C_LO = 4'd4;
    localparam logic [3:0] REG_TONE_C_HI = 4'd5;
    localparam logic [3:0] REG_NOISE_PER = 4'd6;
    localparam logic [3:0] REG_MIXER     = 4'd7;
    localparam logic [3:0] REG_VOL_A     = 4'd8;
    localparam logic [3:0] REG_VOL_B     = 4'd9;
    localparam logic [3:0] REG_VOL_C     = 4'd10;

    // Steps within one chip: noise first, then the three tone channels
    localparam logic [1:0] STEP_NOISE = 2'd0;
    localparam logic [1:0] STEP_CH0   = 2'd1;
    localparam logic [1:0] STEP_CH1   = 2'd2;
    localparam logic [1:0] STEP_CH2   = 2'd3;
    localparam int         STEPS_PER_CHIP = 4;

    // Counter RAM entry: {aux, count}; aux is the LFSR for a noise entry,
    // bit 0 of aux is the square phase for a tone entry
    localparam int CNT_W   = 32;
    localparam int AUX_W   = 18;
    localparam int ENTRY_W = CNT_W + AUX_W;
    localparam logic [ENTRY_W-1:0] ENTRY_RESET = {AUX_W'(1), CNT_W'(0)};

    localparam int AMT_MAX = 15 * 15;
    localparam logic [7:0] SAMPLE_BIAS = 8'h80;

    // Output queue
    localparam int OUT_SLOTS = 2;
    localparam int OUT_PTR_W = $clog2(OUT_SLOTS);
    localparam int OUT_CNT_W = $clog2(OUT_SLOTS + 1);

    typedef struct packed {
        logic [11:0] period;
        logic [3:0]  volume;
        logic        tone_en;
        logic        noise_en;
        logic [4:0]  noise_per;
    } psg_step_cfg_t;

    typedef struct packed {
        logic       vld;
        logic       blank;   // tick with no chip mixed
        logic       first;
        logic       last;
        logic [1:0] step;
    } psg_ctl_t;

    typedef struct packed {
        psg_ctl_t      ctl;
        psg_step_cfg_t cfg;
    } psg_issue_t;

    typedef struct packed {
        logic take;    // input buffer item consumed
        logic wr_go;   // register write applied
        logic start;   // tick started
    } psg_seq_st_t;

endpackage

[rtl/core/psg_ram.sv]
module psg_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/psg_regfile.sv]
module psg_regfile #(
    parameter  int MAX_CHIPS = psg_pkg::DEF_MAX_CHIPS,
    localparam int CHIP_W    = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic                  wr_chip,
    input  logic [3:0]            wr_index,
    input  logic [7:0]            wr_data,
    input  logic [CHIP_W-1:0]     rd_chip,
    input  logic [1:0]            rd_step,
    output psg_pkg::psg_step_cfg_t rd_cfg
);
    import psg_pkg::*;

    logic [7:0] tone_lo_reg   [MAX_CHIPS][3];
    logic [3:0] tone_hi_reg   [MAX_CHIPS][3];
    logic [3:0] vol_reg       [MAX_CHIPS][3];
    logic [4:0] noise_per_reg [MAX_CHIPS];
    logic [5:0] mixer_reg     [MAX_CHIPS];

    logic              wr_ok;
    logic [CHIP_W-1:0] wc;
    logic [1:0]        ch;
    logic [2:0]        nbit;

    // writes to a chip that is not built are dropped
    assign wr_ok = wr_en && ({1'b0, wr_chip} < 2'(MAX_CHIPS));
    assign wc    = CHIP_W'(wr_chip);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHIPS; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    tone_lo_reg[i][j] <= '0;
                    tone_hi_reg[i][j] <= '0;
                    vol_reg[i][j]     <= '0;
                end
                noise_per_reg[i] <= '0;
                mixer_reg[i]     <= '0;
            end
        end
        else if (wr_ok)
        begin
            case (wr_index)
                REG_TONE_A_LO: tone_lo_reg[wc][0] <= wr_data;
                REG_TONE_A_HI: tone_hi_reg[wc][0] <= wr_data[3:0];
                REG_TONE_B_LO: tone_lo_reg[wc][1] <= wr_data;
                REG_TONE_B_HI: tone_hi_reg[wc][1] <= wr_data[3:0];
                REG_TONE_C_LO: tone_lo_reg[wc][2] <= wr_data;
                REG_TONE_C_HI: tone_hi_reg[wc][2] <= wr_data[3:0];
                REG_NOISE_PER: noise_per_reg[wc]  <= wr_data[4:0];
                REG_MIXER:     mixer_reg[wc]      <= wr_data[5:0];
                REG_VOL_A:     vol_reg[wc][0]     <= wr_data[3:0];
                REG_VOL_B:     vol_reg[wc][1]     <= wr_data[3:0];
                REG_VOL_C:     vol_reg[wc][2]     <= wr_data[3:0];
                default: ;
            endcase
        end
    end

    assign ch   = (rd_step == STEP_NOISE) ? 2'd0 : rd_step - 2'd1;
    assign nbit = {1'b0, ch} + 3'd3;

    always_comb
    begin
        rd_cfg.period    = {tone_hi_reg[rd_chip][ch], tone_lo_reg[rd_chip][ch]};
        rd_cfg.volume    = vol_reg[rd_chip][ch];
        rd_cfg.tone_en   = !mixer_reg[rd_chip][ch];
        rd_cfg.noise_en  = !mixer_reg[rd_chip][nbit];
        rd_cfg.noise_per = noise_per_reg[rd_chip];
    end

endmodule

[rtl/core/psg_seq.sv]
module psg_seq #(
    parameter  int MAX_CHIPS = psg_pkg::DEF_MAX_CHIPS,
    localparam int CHIP_W    = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 buf_vld,
    input  logic                 buf_type,
    input  logic [1:0]           chip_num,
    input  logic                 credit_ok,
    output psg_pkg::psg_seq_st_t st,
    output psg_pkg::psg_ctl_t    ctl,
    output logic [CHIP_W-1:0]    ctl_chip
);
    import psg_pkg::*;

    logic              busy_reg, busy_next;
    logic [1:0]        step_reg, step_next;
    logic [CHIP_W-1:0] chip_reg, chip_next;
    logic [CHIP_W-1:0] last_chip_reg, last_chip_next;

    logic              is_tick;
    logic [1:0]        cur_step;
    logic [CHIP_W-1:0] last_chip;

    assign is_tick   = (buf_type == REQ_TICK);
    assign st.start  = !busy_reg && buf_vld && is_tick && credit_ok;
    assign st.wr_go  = !busy_reg && buf_vld && !is_tick;
    assign st.take   = st.start || st.wr_go;

    assign cur_step  = busy_reg ? step_reg : STEP_NOISE;
    assign ctl_chip  = busy_reg ? chip_reg : '0;
    assign last_chip = busy_reg ? last_chip_reg : CHIP_W'(chip_num - 2'd1);

    always_comb
    begin
        ctl.vld   = busy_reg || st.start;
        ctl.blank = st.start && (chip_num == 2'd0);
        ctl.first = st.start;
        ctl.step  = cur_step;
        ctl.last  = ctl.blank ||
                    (ctl.vld && (cur_step == STEP_CH2) && (ctl_chip == last_chip));
    end

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        chip_next      = chip_reg;
        last_chip_next = last_chip_reg;
        if (ctl.vld)
        begin
            if (ctl.last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                busy_next      = 1'b1;
                step_next      = cur_step + 2'd1;
                chip_next      = (cur_step == STEP_CH2) ? ctl_chip + 1'b1 : ctl_chip;
                last_chip_next = last_chip;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= STEP_NOISE;
            chip_reg      <= '0;
            last_chip_reg <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            chip_reg      <= chip_next;
            last_chip_reg <= last_chip_next;
        end
    end

endmodule

[rtl/core/psg_engine.sv]
module psg_engine #(
    parameter  int MAX_CHIPS = psg_pkg::DEF_MAX_CHIPS,
    localparam int CHIP_W    = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  psg_pkg::psg_issue_t issue,
    input  logic [CHIP_W-1:0]   issue_chip,
    input  logic [3:0]          step_inc,
    input  logic [3:0]          gain,
    output logic                res_vld,
    output logic [7:0]          res_data
);
    import psg_pkg::*;

    localparam int DEPTH  = STEPS_PER_CHIP * MAX_CHIPS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = $clog2(3 * MAX_CHIPS * AMT_MAX + 1) + 1;

    // Stage A: read entry. Stage B: update, write back, accumulate.
    // An entry is revisited only after the other steps of its chip have been
    // issued, so a read never meets a pending write to the same entry.
    logic [ADDR_W-1:0]  rd_addr;
    logic               rd_en;
    logic [ENTRY_W-1:0] rd_data;
    logic [DEPTH-1:0]   ent_vld_reg;

    psg_issue_t         b_reg;
    logic [ADDR_W-1:0]  b_addr_reg;
    logic               b_init_reg;
    logic               noise_bit_reg;
    logic signed [SUM_W-1:0] acc_reg;

    logic [ENTRY_W-1:0] cur;
    logic [CNT_W-1:0]   cnt, cnt_sum, cnt_red, new_cnt;
    logic [AUX_W-1:0]   aux, aux_sh, new_aux;
    logic [11:0]        per_sel;
    logic               over, wen, ch_on, high;
    logic [7:0]         amt;
    logic signed [SUM_W-1:0] delta, acc_next, acc_sh, res_sum;

    assign rd_addr = ADDR_W'({issue_chip, issue.ctl.step});
    assign rd_en   = issue.ctl.vld && !issue.ctl.blank;

    psg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (wen),
        .waddr (b_addr_reg),
        .wdata ({new_aux, new_cnt}),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg <= '0;
        end
        else
        begin
            b_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        b_addr_reg <= rd_addr;
        b_init_reg <= !ent_vld_reg[rd_addr];
    end

    // stage B
    assign cur     = b_init_reg ? ENTRY_RESET : rd_data;
    assign cnt     = cur[CNT_W-1:0];
    assign aux     = cur[ENTRY_W-1:CNT_W];
    assign per_sel = (b_reg.ctl.step == STEP_NOISE) ? 12'(b_reg.cfg.noise_per)
                                                    : b_reg.cfg.period;
    assign cnt_sum = cnt + CNT_W'(step_inc);
    assign over    = cnt_sum > CNT_W'(per_sel);
    assign cnt_red = cnt_sum - CNT_W'(per_sel);
    // 18-bit LFSR, taps 0 and 3; feedback lands in bit 17, then the whole
    // register shifts right so bit 17 empties
    assign aux_sh  = {1'b0, aux[AUX_W-1] ^ aux[0] ^ aux[3], aux[AUX_W-2:1]};

    assign ch_on = (b_reg.cfg.period != '0) && (b_reg.cfg.volume != '0) &&
                   (b_reg.cfg.tone_en || b_reg.cfg.noise_en);
    assign high  = (!b_reg.cfg.tone_en || aux[0]) &&
                   (!b_reg.cfg.noise_en || noise_bit_reg);
    assign amt   = {4'b0, gain} * {4'b0, b_reg.cfg.volume};

    always_comb
    begin
        new_cnt = cnt;
        new_aux = aux;
        delta   = '0;
        if (b_reg.ctl.step == STEP_NOISE)
        begin
            if (per_sel != '0)
            begin
                new_cnt = over ? cnt_red : cnt_sum;
                new_aux = over ? aux_sh : aux;
            end
        end
        else if (ch_on)
        begin
            new_cnt = over ? cnt_red : cnt_sum;
            new_aux = over ? {aux[AUX_W-1:1], ~aux[0]} : aux;
            delta   = high ? SUM_W'(amt) : -SUM_W'(amt);
        end
    end

    assign wen      = b_reg.ctl.vld && !b_reg.ctl.blank;
    assign acc_next = (b_reg.ctl.first ? SUM_W'(0) : acc_reg) + delta;
    assign acc_sh   = acc_next >>> 3;
    assign res_sum  = acc_sh + SUM_W'(SAMPLE_BIAS);
    assign res_vld  = b_reg.ctl.vld && b_reg.ctl.last;
    assign res_data = res_sum[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_vld_reg   <= '0;
            noise_bit_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            if (wen)
            begin
                ent_vld_reg[b_addr_reg] <= 1'b1;
            end
            if (wen && (b_reg.ctl.step == STEP_NOISE))
            begin
                noise_bit_reg <= new_aux[0];
            end
            if (b_reg.ctl.vld)
            begin
                acc_reg <= acc_next;
            end
        end
    end

endmodule

[rtl/core/psg_tone_noise_synth.sv]
// Tone/noise sound generator mixer, one or two chips of three tone channels
// and one noise source each.
// Input channel (in_valid/in_stall): req_type selects a register write
// (chip_select, reg_index, reg_value) or a sample tick. Writes give no item
// on the output; each tick gives exactly one sample_out item, 128 = silence.
// Config channel (cfg_valid/cfg_ready): index 0 chip count, 1 step
// increment, 2 channel gain. Always ready; write only while idle.
// Timing: a write is applied as it leaves the input buffer, once no tick
// is running. A tick issues, per mixed chip, the noise step and then the
// three tone steps; the counter RAM is read once per noise or tone step,
// one step a cycle, and ticks stream back to back while the output queue
// has a slot for their samples. A tick with no chip mixed issues only a
// blank step that reads no counter entry.
// A one-item input buffer takes the next item while a tick is running.
// Output: a two-entry queue; a tick only starts when its result has a
// slot, so a stalled receiver backs up into in_stall, never drops data.
// Reset: config back to 1 chip, increment 9, gain 11; sound registers
// zero; counter RAM entries read as their reset value until first
// written (per-entry valid bits), so no clearing pass is needed.
module psg_tone_noise_synth #(
    parameter  int MAX_CHIPS = psg_pkg::DEF_MAX_CHIPS,
    localparam int CHIP_W    = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1
) (
    input  logic       clk,
    input  logic       rst_n,
    // input items
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       req_type,
    input  logic       chip_select,
    input  logic [3:0] reg_index,
    input  logic [7:0] reg_value,
    // output items
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] sample_out,
    // configuration
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data
);
    import psg_pkg::*;

    // block config
    logic [1:0] chip_count_reg;
    logic [3:0] step_inc_reg;
    logic [3:0] gain_reg;
    logic [1:0] chip_num;

    // input buffer
    logic       buf_vld_reg;
    logic       buf_type_reg;
    logic       buf_chip_reg;
    logic [3:0] buf_idx_reg;
    logic [7:0] buf_val_reg;
    logic       in_acc;

    // sequencer / engine
    psg_seq_st_t       seq_st;
    psg_ctl_t          ctl;
    logic [CHIP_W-1:0] ctl_chip;
    psg_step_cfg_t     rd_cfg;
    psg_issue_t        issue;
    logic              res_vld;
    logic [7:0]        res_data;
    logic              credit_ok;

    // output queue
    logic [7:0]           q_data_reg [OUT_SLOTS];
    logic [OUT_PTR_W-1:0] q_wr_reg, q_rd_reg;
    logic [OUT_CNT_W-1:0] q_cnt_reg, q_cnt_next;
    logic [OUT_CNT_W-1:0] pend_reg, pend_next;
    logic                 q_pop;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chip_count_reg <= RST_CHIP_COUNT;
            step_inc_reg   <= RST_STEP_INC;
            gain_reg       <= RST_GAIN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CHIP_COUNT: chip_count_reg <= cfg_data[1:0];
                CFG_STEP_INC:   step_inc_reg   <= cfg_data;
                CFG_GAIN:       gain_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // chip count above the built number saturates
    assign chip_num = (chip_count_reg > 2'(MAX_CHIPS)) ? 2'(MAX_CHIPS) : chip_count_reg;

    // ---------------- input buffer ----------------
    assign in_stall = buf_vld_reg && !seq_st.take;
    assign in_acc   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_vld_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            buf_vld_reg <= 1'b1;
        end
        else if (seq_st.take)
        begin
            buf_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            buf_type_reg <= req_type;
            buf_chip_reg <= chip_select;
            buf_idx_reg  <= reg_index;
            buf_val_reg  <= reg_value;
        end
    end

    // ---------------- step sequencer ----------------
    // a tick may start only if its sample has a queue slot reserved
    assign credit_ok = (pend_reg + q_cnt_reg) < OUT_CNT_W'(OUT_SLOTS);

    psg_seq #(
        .MAX_CHIPS (MAX_CHIPS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .buf_vld   (buf_vld_reg),
        .buf_type  (buf_type_reg),
        .chip_num  (chip_num),
        .credit_ok (credit_ok),
        .st        (seq_st),
        .ctl       (ctl),
        .ctl_chip  (ctl_chip)
    );

    psg_regfile #(
        .MAX_CHIPS (MAX_CHIPS)
    ) u_regfile (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (seq_st.wr_go),
        .wr_chip  (buf_chip_reg),
        .wr_index (buf_idx_reg),
        .wr_data  (buf_val_reg),
        .rd_chip  (ctl_chip),
        .rd_step  (ctl.step),
        .rd_cfg   (rd_cfg)
    );

    assign issue.ctl = ctl;
    assign issue.cfg = rd_cfg;

    psg_engine #(
        .MAX_CHIPS (MAX_CHIPS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (issue),
        .issue_chip (ctl_chip),
        .step_inc   (step_inc_reg),
        .gain       (gain_reg),
        .res_vld    (res_vld),
        .res_data   (res_data)
    );

    // ---------------- output queue ----------------
    assign q_pop      = out_valid && !out_stall;
    assign q_cnt_next = q_cnt_reg + OUT_CNT_W'(res_vld) - OUT_CNT_W'(q_pop);
    assign pend_next  = pend_reg + OUT_CNT_W'(seq_st.start) - OUT_CNT_W'(res_vld);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
            pend_reg  <= '0;
        end
        else
        begin
            if (res_vld)
            begin
                q_wr_reg <= q_wr_reg + 1'b1;
            end
            if (q_pop)
            begin
                q_rd_reg <= q_rd_reg + 1'b1;
            end
            q_cnt_reg <= q_cnt_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_vld)
        begin
            q_data_reg[q_wr_reg] <= res_data;
        end
    end

    assign out_valid  = (q_cnt_reg != '0);
    assign sample_out = q_data_reg[q_rd_reg];

endmodule

[rtl/core/psg_chk.sv]
module psg_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       req_type,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] sample_out,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic [1:0] cfg_index,
    input logic [3:0] cfg_data
);
    import psg_pkg::*;

    // ticks taken whose sample has not been delivered yet
    logic [2:0] pend_reg;
    logic       mute_reg;
    logic       tick_in, smp_out;

    assign tick_in = in_valid && !in_stall && (req_type == REQ_TICK);
    assign smp_out = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            mute_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_reg + 3'(tick_in) - 3'(smp_out);
            if (cfg_valid && cfg_ready && (cfg_index == CFG_CHIP_COUNT))
            begin
                mute_reg <= (cfg_data[1:0] == 2'd0);
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_out))
        else $error("stalled sample changed or dropped");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 3'd0)
        else $error("sample without a tick");

    a_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd3)
        else $error("tick backlog beyond buffer and queue depth");

    a_mute: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mute_reg |-> sample_out == SAMPLE_BIAS)
        else $error("no chip mixed but sample not silent");

endmodule

bind psg_tone_noise_synth psg_chk u_psg_chk (.*);

[dv/psg_tone_noise_synth_test.sv]
module psg_tone_noise_synth_test;
    timeunit 1ns;
    timeprecision 1ps;

    import psg_pkg::*;

    localparam int N_CHIPS     = DEF_MAX_CHIPS;
    // drain pause: one tick of two chips plus the output queue, with margin
    localparam int SETTLE      = 16;
    localparam int LONG_HOLD   = 120;  // receiver hold-off, long enough to back up the input
    localparam int QUIET_LIMIT = 2000; // cycles with no handshake at all before giving up
    localparam int STREAM_LEN  = 115;

    typedef struct packed {
        logic       req;
        logic       chip;
        logic [3:0] idx;
        logic [7:0] val;
    } synth_req_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       req_type = REQ_TICK;
    logic       chip_select = 1'b0;
    logic [3:0] reg_index = 4'd0;
    logic [7:0] reg_value = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] sample_out;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = CFG_CHIP_COUNT;
    logic [3:0] cfg_data = 4'd0;

    psg_tone_noise_synth dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .chip_select (chip_select),
        .reg_index   (reg_index),
        .reg_value   (reg_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample_out  (sample_out),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Sound generator prediction: register file, dividers, square phases
    // and noise shift registers of both chips, plus the block settings.
    // ------------------------------------------------------------------
    logic [7:0]  sound_reg_m [16*N_CHIPS];
    logic [31:0] tone_div    [3*N_CHIPS];
    logic [31:0] noise_div   [N_CHIPS];
    logic        tone_sq     [3*N_CHIPS];
    logic [17:0] noise_lfsr  [N_CHIPS];
    logic [1:0]  mix_chips;
    logic [3:0]  mix_step;
    logic [3:0]  mix_gain;

    // One chip's contribution to a sample; steps noise first, then tones.
    function automatic int chip_sum(int chip);
        logic [7:0]  mix;
        logic [4:0]  nper;
        logic [11:0] per;
        logic [3:0]  vol;
        logic        tone_on;
        logic        noise_on;
        logic        up;
        logic [17:0] sr;
        int          amt;
        int          acc;
        int          k;
        acc = 0;
        mix = sound_reg_m[16*chip + REG_MIXER];
        nper = sound_reg_m[16*chip + REG_NOISE_PER][4:0];
        if (nper != 0)
        begin
            noise_div[chip] += 32'(mix_step);
            // reduced at most once per tick, so a short period keeps growing
            if (noise_div[chip] > 32'(nper))
            begin
                sr = noise_lfsr[chip];
                noise_div[chip] -= 32'(nper);
                sr[17] = sr[17] ^ sr[0] ^ sr[3];
                noise_lfsr[chip] = sr >> 1;
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            k = 3*chip + c;
            per = {sound_reg_m[16*chip + 2*c + 1][3:0], sound_reg_m[16*chip + 2*c]};
            vol = sound_reg_m[16*chip + REG_VOL_A + c][3:0];
            tone_on = !mix[c];      // mixer bits are active low
            noise_on = !mix[c + 3];
            if (per != 0 && vol != 0 && (tone_on || noise_on))
            begin
                up = 1'b1;
                if (tone_on)
                    up = up & tone_sq[k];
                if (noise_on)
                    up = up & noise_lfsr[chip][0];
                amt = int'(mix_gain) * int'(vol);
                acc += up ? amt : -amt;
                tone_div[k] += 32'(mix_step);
                if (tone_div[k] > 32'(per))
                begin
                    tone_div[k] -= 32'(per);
                    tone_sq[k] = ~tone_sq[k];
                end
            end
        end
        return acc;
    endfunction

    // Sample for one tick: floor(sum / 8) biased by 128, wrapping mod 256.
    function automatic logic [7:0] predict_sample();
        int n;
        int total;
        n = (int'(mix_chips) > N_CHIPS) ? N_CHIPS : int'(mix_chips);
        total = 0;
        for (int i = 0; i < n; i++)
            total += chip_sum(i);
        return 8'(int'(SAMPLE_BIAS) + (total >>> 3));
    endfunction

    // ------------------------------------------------------------------
    // Monitor: updates the model on every accepted item, predicts on ticks, checks every accepted sample
    // ------------------------------------------------------------------
    logic [7:0] sample_q [$];
    int err_count = 0;
    int items_taken = 0;
    int ticks_taken = 0;
    int writes_taken = 0;
    int samples_checked = 0;
    int cfg_taken = 0;
    int quiet_cycles = 0;
    logic in_took = 1'b0;
    logic out_took = 1'b0;

    task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
        $display("mismatch at %0t: %s, expected %0d got %0d", $realtime, what, want, got);
        err_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        logic [7:0] want;
        if (!rst_n)
        begin
            in_took <= 1'b0;
            out_took <= 1'b0;
            quiet_cycles <= 0;
            foreach (sound_reg_m[i]) sound_reg_m[i] = 8'd0;
            foreach (tone_div[i])
            begin
                tone_div[i] = 32'd0;
                tone_sq[i] = 1'b1;
            end
            foreach (noise_div[i])
            begin
                noise_div[i] = 32'd0;
                noise_lfsr[i] = 18'd1;
            end
            mix_chips = RST_CHIP_COUNT;
            mix_step = RST_STEP_INC;
            mix_gain = RST_GAIN;
        end
        else
        begin
            in_took <= in_valid && !in_stall;
            out_took <= out_valid && !out_stall;
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;

            // results first: an item taken this edge cannot have its sample out yet
            if (out_valid && !out_stall)
            begin
                if (sample_q.size() == 0)
                    report_mismatch("sample with none pending", 8'd0, sample_out);
                else
                begin
                    want = sample_q.pop_front();
                    if (sample_out !== want)
                        report_mismatch("sample_out", want, sample_out);
                end
                samples_checked++;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CHIP_COUNT: mix_chips = cfg_data[1:0];
                    CFG_STEP_INC:   mix_step = cfg_data;
                    CFG_GAIN:       mix_gain = cfg_data;
                    default: ;
                endcase
                cfg_taken++;
            end

            if (in_valid && !in_stall)
            begin
                items_taken <= items_taken + 1;
                if (req_type == REQ_TICK)
                begin
                    sample_q.push_back(predict_sample());
                    ticks_taken++;
                end
                else
                begin
                    sound_reg_m[16*int'(chip_select) + int'(reg_index)] = reg_value;
                    writes_taken++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: presents queued items at the falling edge, holds a stalled
    // item, and waits a random idle gap, bounded by in_gap_max, before each new one.
    // ------------------------------------------------------------------
    synth_req_t pending_q [$];
    int items_queued = 0;
    int in_gap = 0;
    int in_gap_max = 4;

    always @(negedge clk)
    begin : driver
        synth_req_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else if (!(in_valid && !in_took))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_q.size() != 0)
            begin
                nxt = pending_q.pop_front();
                req_type <= nxt.req;
                chip_select <= nxt.chip;
                reg_index <= nxt.idx;
                reg_value <= nxt.val;
                in_valid <= 1'b1;
                in_gap = $urandom_range(0, in_gap_max);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall after each sample, plus a long hold-off on
    // request, counted here so the sender keeps streaming meanwhile.
    // ------------------------------------------------------------------
    int out_gap_max = 4;
    int out_wait = 0;
    int hold_asks = 0;
    int hold_done = 0;
    int hold_left = 0;

    always @(negedge clk)
    begin : receiver
        if (rst_n)
        begin
            if (hold_done != hold_asks)
            begin
                hold_done = hold_asks;
                hold_left = LONG_HOLD;
            end
            if (out_took)
                out_wait = $urandom_range(0, out_gap_max);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (out_wait > 0)
            begin
                out_wait--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog: no handshake of any kind for too long means the block hung
    initial
    begin : watchdog
        @(posedge rst_n);
        while (quiet_cycles < QUIET_LIMIT)
            @(negedge clk);
        $display("timeout: no handshake for %0d cycles, %0d samples pending",
                 QUIET_LIMIT, sample_q.size());
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_item(logic req, logic chip, logic [3:0] idx, logic [7:0] val);
        synth_req_t it;
        it.req = req;
        it.chip = chip;
        it.idx = idx;
        it.val = val;
        pending_q.push_back(it);
        items_queued++;
    endtask

    task automatic queue_write(logic chip, logic [3:0] idx, logic [7:0] val);
        queue_item(REQ_WRITE, chip, idx, val);
    endtask

    // fields other than req_type are don't-care on a tick; keep them moving
    task automatic queue_tick();
        queue_item(REQ_TICK, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                   8'($urandom_range(0, 255)));
    endtask

    // Block until every queued item is taken and every sample seen, then let
    // a write still in flight land before anything else happens.
    task automatic wait_drained();
        while (items_taken != items_queued || sample_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_config(logic [1:0] idx, logic [3:0] data);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Full voice program for both chips. Loud: max volume, longest period,
    // noise off, so the first samples overflow the byte.
    task automatic load_voices(bit loud);
        logic [7:0] v;
        for (int chip = 0; chip < N_CHIPS; chip++)
        begin
            for (int r = 0; r <= int'(REG_VOL_C); r++)
            begin
                if (loud)
                begin
                    if (r == int'(REG_MIXER))
                        v = (chip == 0) ? 8'h3a : 8'h38;
                    else if (r == int'(REG_NOISE_PER))
                        v = 8'h00;
                    else
                        v = 8'hff;
                end
                else if (r <= int'(REG_TONE_C_HI) && r[0])
                    // period high: mostly 0 or 1 so squares actually toggle
                    v = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
                else if (r <= int'(REG_TONE_C_HI))
                    v = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
                else
                    v = 8'($urandom);
                queue_write(1'(chip), 4'(r), v);
            end
        end
    endtask

    // mostly ticks, with stray writes to any register of either chip
    task automatic queue_stream(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 85)
                queue_tick();
            else
                queue_write(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                            8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int base;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // silence straight out of reset
        queue_tick();
        // chip 0 tone A alone, longest period (upper period bits masked)
        queue_write(1'b0, REG_TONE_A_LO, 8'hff);
        queue_write(1'b0, REG_TONE_A_HI, 8'hff);
        queue_write(1'b0, REG_VOL_A, 8'hff);
        queue_write(1'b0, REG_MIXER, 8'h3e);
        queue_tick();
        queue_tick();
        // tone B with a period below the increment, noise at its longest period
        queue_write(1'b0, REG_TONE_B_LO, 8'h01);
        queue_write(1'b0, REG_VOL_B, 8'h0f);
        queue_write(1'b0, REG_NOISE_PER, 8'h1f);
        queue_write(1'b0, REG_MIXER, 8'h30);
        queue_tick();
        queue_tick();
        // chip 1 set up but not mixed yet; unused registers written too
        queue_write(1'b1, REG_NOISE_PER, 8'h01);
        queue_write(1'b1, REG_MIXER, 8'h00);
        queue_write(1'b1, 4'd15, 8'haa);
        queue_write(1'b1, 4'd11, 8'h55);
        queue_tick();

        // chip count two, zero, and three (saturates to two)
        write_config(CFG_CHIP_COUNT, 4'd2);
        queue_tick();
        queue_tick();
        write_config(CFG_CHIP_COUNT, 4'd0);
        queue_tick();
        write_config(CFG_CHIP_COUNT, 4'd3);
        queue_tick();
        // dividers frozen, then all channels muted by zero gain
        write_config(CFG_CHIP_COUNT, 4'd1);
        write_config(CFG_STEP_INC, 4'd0);
        queue_tick();
        write_config(CFG_STEP_INC, 4'd9);
        write_config(CFG_GAIN, 4'd0);
        queue_tick();

        // Random phases, each with its own settings and idling profile.
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: begin
                    write_config(CFG_CHIP_COUNT, 4'd2);
                    write_config(CFG_STEP_INC, 4'd15);
                    write_config(CFG_GAIN, 4'd15);
                end
                1: begin
                    write_config(CFG_CHIP_COUNT, 4'd1);
                    write_config(CFG_STEP_INC, 4'd1);
                    write_config(CFG_GAIN, 4'd1);
                end
                2: begin
                    write_config(CFG_CHIP_COUNT, 4'd3);
                    write_config(CFG_STEP_INC, RST_STEP_INC);
                    write_config(CFG_GAIN, RST_GAIN);
                end
                default: begin
                    write_config(CFG_CHIP_COUNT, 4'($urandom_range(1, 3)));
                    write_config(CFG_STEP_INC, 4'($urandom_range(1, 15)));
                    write_config(CFG_GAIN, 4'($urandom_range(1, 15)));
                end
            endcase
            // every third phase runs with no idling on either side
            in_gap_max = (p % 3 == 1) ? 0 : 4;
            out_gap_max = (p % 3 == 1) ? 0 : 4;
            base = items_queued;
            load_voices(p == 0);
            if (p == 3)
            begin
                // sender stops mid-stream until every sample is back
                queue_stream(STREAM_LEN / 2);
                wait_drained();
                queue_stream(STREAM_LEN - STREAM_LEN / 2);
            end
            else
                queue_stream(STREAM_LEN);
            if (p == 1)
            begin
                // back-to-back ticks while the receiver holds off: output
                // queue fills and in_stall must rise
                while (items_taken < base + 40)
                    @(negedge clk);
                hold_asks++;
            end
        end

        wait_drained();
        $display("covered %0d register writes, %0d ticks, %0d samples checked, %0d config writes",
                 writes_taken, ticks_taken, samples_checked, cfg_taken);
        $display("chip counts 0-3, increment and gain 0-15, long output hold, drained pauses");
        if (err_count == 0 && sample_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/core/psg_pkg.sv
rtl/core/psg_ram.sv
rtl/core/psg_regfile.sv
rtl/core/psg_seq.sv
rtl/core/psg_engine.sv
rtl/core/psg_tone_noise_synth.sv
rtl/core/psg_chk.sv
dv/psg_tone_noise_synth_test.sv
